/* rtl/cfrt_pkg.sv */
package cfrt_pkg;

    // Fixed field widths
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 6;
    localparam int TAPS_W     = 7;
    localparam int OUT_W      = 38;
    localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

    localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd33;

    // Command codes carried in tuser bit 0
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Control broadcast to every cell
    typedef struct packed {
        logic                         shift;
        logic                         load;
        logic [COEF_IDX_W-1:0]        coef_index;
        logic signed [COEF_W-1:0]     coef_value;
    } t_cell_ctl;

    // Sequencer status toward the top level
    typedef struct packed {
        logic in_ready;
        logic out_load;
        logic out_valid;
    } t_seq_out;

    typedef enum logic {
        S_IDLE,
        S_SUM
    } t_seq_state;

endpackage

/* rtl/complex_fir_real_taps_core.sv */
// Channel   Dir  Transfer contents
// s_axis    in   tdata: sample_i, sample_q, coef_index, coef_value; tuser: cmd, first_of_block
// m_axis    out  tdata: out_i, out_q
// cfg       in   taps_in_use write (write enable + data, no handshake)
//
// A coefficient load makes no output transfer.
// A sample's partial sum walks one cell per cycle down the chain of MAX_TAPS tap
// cells and is then taken into the output register.
// One sample is in the chain at a time; s_axis_tready is low meanwhile.
// A stalled result holds in the output register; a finished sum waits in the chain.
// Synchronous reset clears history, coefficients and sets taps_in_use to 33.
module complex_fir_real_taps_core #(
    parameter int  MAX_TAPS    = 64,
    parameter int  SAMPLE_BITS = 16,
    localparam int IN_BITS     = 2 * SAMPLE_BITS + cfrt_pkg::COEF_IDX_W + cfrt_pkg::COEF_W,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // low to high: sample_i, sample_q, coef_index, coef_value, zero pad
    input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
    // low to high: cmd, first_of_block
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // low to high: out_i, out_q, zero pad
    output logic [cfrt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [cfrt_pkg::TAPS_W-1:0]         i_cfg_wr_data
);
    import cfrt_pkg::*;

    localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);

    logic                          w_accept, w_cmd, w_first;
    logic signed [SAMPLE_BITS-1:0] w_smp_i, w_smp_q;
    t_cell_ctl                     w_ctl;
    t_seq_out                      w_seq;
    logic [TAPS_W-1:0]             r_taps;
    logic [TAP_CNT_W-1:0]          w_taps_eff;
    logic signed [OUT_W-1:0]       r_out_i, r_out_q;

    logic signed [SAMPLE_BITS-1:0] w_hist_i [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] w_hist_q [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] w_feed_i [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] w_feed_q [MAX_TAPS];
    logic signed [OUT_W-1:0]       w_sum_i  [MAX_TAPS + 1];
    logic signed [OUT_W-1:0]       w_sum_q  [MAX_TAPS + 1];

    // Input unpacking
    assign w_cmd    = s_axis_tuser[0];
    assign w_first  = s_axis_tuser[1];
    assign w_smp_i  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_smp_q  = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign w_ctl.shift      = w_accept && (w_cmd == CMD_FILTER);
    assign w_ctl.load       = w_accept && (w_cmd == CMD_LOAD);
    assign w_ctl.coef_index = s_axis_tdata[2*SAMPLE_BITS+COEF_IDX_W-1:2*SAMPLE_BITS];
    assign w_ctl.coef_value = s_axis_tdata[IN_BITS-1:2*SAMPLE_BITS+COEF_IDX_W];

    // Tap count register and its clamped value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= TAPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_taps <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_taps == '0) begin
            w_taps_eff = TAP_CNT_W'(1);
        end else if (32'(r_taps) > MAX_TAPS) begin
            w_taps_eff = TAP_CNT_W'(MAX_TAPS);
        end else begin
            w_taps_eff = TAP_CNT_W'(r_taps);
        end
    end

    // Chain of tap cells; a block start zeroes the shifted-in history
    assign w_sum_i[0] = '0;
    assign w_sum_q[0] = '0;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_feed_i[k] = w_smp_i;
            assign w_feed_q[k] = w_smp_q;
        end else begin : g_body
            assign w_feed_i[k] = w_first ? '0 : w_hist_i[k-1];
            assign w_feed_q[k] = w_first ? '0 : w_hist_q[k-1];
        end

        cfrt_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .IDX         (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_en     (k < 32'(w_taps_eff)),
            .i_hist_i (w_feed_i[k]),
            .i_hist_q (w_feed_q[k]),
            .i_sum_i  (w_sum_i[k]),
            .i_sum_q  (w_sum_q[k]),
            .o_hist_i (w_hist_i[k]),
            .o_hist_q (w_hist_q[k]),
            .o_sum_i  (w_sum_i[k+1]),
            .o_sum_q  (w_sum_q[k+1])
        );
    end

    // Sequencer
    cfrt_seq #(
        .MAX_TAPS (MAX_TAPS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_ctl.shift),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_seq)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_seq.out_load) begin
            r_out_i <= w_sum_i[MAX_TAPS];
            r_out_q <= w_sum_q[MAX_TAPS];
        end
    end

    assign s_axis_tready = w_seq.in_ready;
    assign m_axis_tvalid = w_seq.out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - 2 * OUT_W)'(0), r_out_q, r_out_i};

`ifndef SYNTHESIS
    // A sample occupies the chain: no transfer in the next cycle
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.shift |=> !s_axis_tready)
        else $error("input accepted while a sum is in the chain");

    // A coefficient load leaves the block ready
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |=> s_axis_tready)
        else $error("coefficient load made the block busy");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seq.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while stalled");

    // Output valid rises only from a sequencer load
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_seq.out_load))
        else $error("output valid without a load");
`endif

endmodule

/* rtl/cfrt_cell.sv */
module cfrt_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int IDX         = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cfrt_pkg::t_cell_ctl                    i_ctl,
    input  logic                                   i_en,
    input  logic signed [SAMPLE_BITS-1:0]          i_hist_i,
    input  logic signed [SAMPLE_BITS-1:0]          i_hist_q,
    input  logic signed [cfrt_pkg::OUT_W-1:0]      i_sum_i,
    input  logic signed [cfrt_pkg::OUT_W-1:0]      i_sum_q,
    output logic signed [SAMPLE_BITS-1:0]          o_hist_i,
    output logic signed [SAMPLE_BITS-1:0]          o_hist_q,
    output logic signed [cfrt_pkg::OUT_W-1:0]      o_sum_i,
    output logic signed [cfrt_pkg::OUT_W-1:0]      o_sum_q
);
    import cfrt_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_W;

    logic signed [SAMPLE_BITS-1:0] r_hist_i, r_hist_q, n_hist_i, n_hist_q;
    logic signed [COEF_W-1:0]      r_coef, n_coef;
    logic signed [PROD_W-1:0]      r_prod_i, r_prod_q;
    logic signed [OUT_W-1:0]       r_sum_i, r_sum_q;
    logic signed [OUT_W-1:0]       n_term_i, n_term_q;

    // History and coefficient next values
    always_comb begin
        n_hist_i = r_hist_i;
        n_hist_q = r_hist_q;
        n_coef   = r_coef;
        if (i_ctl.shift) begin
            n_hist_i = i_hist_i;
            n_hist_q = i_hist_q;
        end
        if (i_ctl.load && (32'(i_ctl.coef_index) == IDX)) begin
            n_coef = i_ctl.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_i <= '0;
            r_hist_q <= '0;
            r_coef   <= '0;
        end else begin
            r_hist_i <= n_hist_i;
            r_hist_q <= n_hist_q;
            r_coef   <= n_coef;
        end
    end

    // Tap product, then add into the sum passing down the chain
    assign n_term_i = i_en ? OUT_W'(r_prod_i) : '0;
    assign n_term_q = i_en ? OUT_W'(r_prod_q) : '0;

    always_ff @(posedge i_clk) begin
        r_prod_i <= PROD_W'(r_hist_i) * PROD_W'(r_coef);
        r_prod_q <= PROD_W'(r_hist_q) * PROD_W'(r_coef);
        r_sum_i  <= i_sum_i + n_term_i;
        r_sum_q  <= i_sum_q + n_term_q;
    end

    assign o_hist_i = r_hist_i;
    assign o_hist_q = r_hist_q;
    assign o_sum_i  = r_sum_i;
    assign o_sum_q  = r_sum_q;

endmodule

/* rtl/cfrt_seq.sv */
module cfrt_seq #(
    parameter int MAX_TAPS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_out_ready,
    output cfrt_pkg::t_seq_out o_ctl
);
    import cfrt_pkg::*;

    // Last count value: the sum at the chain end has settled after the shift
    localparam int LAST_CNT = MAX_TAPS + 1;
    localparam int CNT_W    = $clog2(LAST_CNT + 1);

    t_seq_state       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_cnt == CNT_W'(LAST_CNT)) begin
                    // wait until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_ctl.in_ready  = (r_state == S_IDLE);
    assign o_ctl.out_load  = w_load;
    assign o_ctl.out_valid = r_out_valid;

endmodule

/* tb/sv/complex_fir_real_taps_checker.sv */
`timescale 1ns / 1ps

// Watches the sample/coefficient stream, the result stream and the tap-count
// register port. Keeps its own copy of the coefficient bank and the I/Q delay
// line, predicts every filter result and compares it against the output
// transfers in order.
module complex_fir_real_taps_checker #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int IN_TDATA_W  = 56
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // low to high: sample_i, sample_q, coef_index, coef_value, zero pad
    input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
    // low to high: cmd, first_of_block
    input  logic [1:0]                          s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // low to high: out_i, out_q, zero pad
    input  logic [cfrt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [cfrt_pkg::TAPS_W-1:0]         i_cfg_wr_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int OUT_W  = cfrt_pkg::OUT_W;
    localparam int COEF_W = cfrt_pkg::COEF_W;
    localparam int IDX_LO = 2 * SAMPLE_BITS;
    localparam int VAL_LO = IDX_LO + cfrt_pkg::COEF_IDX_W;

    typedef struct packed {
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
    } t_fir_out;

    t_fir_out                       expected_outputs[$];
    logic signed [COEF_W-1:0]       coef_bank [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]  delay_i   [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]  delay_q   [MAX_TAPS];
    logic [cfrt_pkg::TAPS_W-1:0]    taps_cfg;
    int                             fail_count;

    assign o_fail_count = fail_count;

    // Push one sample into the delay line and form the exact I/Q sums
    function automatic t_fir_out filter_sample(input logic first,
                                               input logic signed [SAMPLE_BITS-1:0] si,
                                               input logic signed [SAMPLE_BITS-1:0] sq);
        int       n;
        longint   acc_i;
        longint   acc_q;
        t_fir_out res;
        if (first) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                delay_i[k] = '0;
                delay_q[k] = '0;
            end
        end
        for (int k = MAX_TAPS - 1; k > 0; k--) begin
            delay_i[k] = delay_i[k-1];
            delay_q[k] = delay_q[k-1];
        end
        delay_i[0] = si;
        delay_q[0] = sq;
        // zero taps behaves as one, oversize clamps to the bank depth
        n = int'(taps_cfg);
        if (n < 1) n = 1;
        if (n > MAX_TAPS) n = MAX_TAPS;
        acc_i = 0;
        acc_q = 0;
        for (int k = 0; k < n; k++) begin
            acc_i += longint'(coef_bank[k]) * longint'(delay_i[k]);
            acc_q += longint'(coef_bank[k]) * longint'(delay_q[k]);
        end
        res.re = acc_i[OUT_W-1:0];
        res.im = acc_q[OUT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_fir_out                    got;
        t_fir_out                    want;
        logic [cfrt_pkg::COEF_IDX_W-1:0] idx;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                coef_bank[k] = '0;
                delay_i[k]   = '0;
                delay_q[k]   = '0;
            end
            taps_cfg = cfrt_pkg::TAPS_RESET;
            expected_outputs.delete();
        end else begin
            if (i_cfg_wr_en) begin
                taps_cfg = i_cfg_wr_data;
            end
            // result transfer: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got.re = m_axis_tdata[OUT_W-1:0];
                got.im = m_axis_tdata[2*OUT_W-1:OUT_W];
                if (expected_outputs.size() == 0) begin
                    $error("result transfer with nothing pending: out_i %0d, out_q %0d",
                           $signed(got.re), $signed(got.im));
                    fail_count++;
                end else begin
                    want = expected_outputs.pop_front();
                    if (got.re !== want.re) begin
                        $error("out_i: expected %0d, actual %0d",
                               $signed(want.re), $signed(got.re));
                        fail_count++;
                    end
                    if (got.im !== want.im) begin
                        $error("out_q: expected %0d, actual %0d",
                               $signed(want.im), $signed(got.im));
                        fail_count++;
                    end
                end
            end
            // input transfer: coefficient load or filtered sample
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == cfrt_pkg::CMD_LOAD) begin
                    idx = s_axis_tdata[VAL_LO-1:IDX_LO];
                    if (int'(idx) < MAX_TAPS) begin
                        coef_bank[idx] = s_axis_tdata[VAL_LO+COEF_W-1:VAL_LO];
                    end
                end else begin
                    expected_outputs.push_back(
                        filter_sample(s_axis_tuser[1],
                                      s_axis_tdata[SAMPLE_BITS-1:0],
                                      s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
                end
            end
        end
        o_pending = expected_outputs.size();
    end

endmodule

/* tb/sv/complex_fir_real_taps_core_test.sv */
`timescale 1ns / 1ps

module complex_fir_real_taps_core_test;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_W      = cfrt_pkg::COEF_W;
    localparam int IDX_W       = cfrt_pkg::COEF_IDX_W;
    localparam int IN_BITS     = 2 * SAMPLE_BITS + IDX_W + COEF_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 75;

    localparam logic [COEF_W-1:0] WORD_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] WORD_MAX = {1'b0, {(COEF_W-1){1'b1}}};

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    // low to high: sample_i, sample_q, coef_index, coef_value, zero pad
    logic [IN_TDATA_W-1:0]              s_axis_tdata;
    // low to high: cmd, first_of_block
    logic [1:0]                         s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // low to high: out_i, out_q, zero pad
    logic [cfrt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                               i_cfg_wr_en;
    logic [cfrt_pkg::TAPS_W-1:0]        i_cfg_wr_data;

    int fail_count;
    int pending;
    bit idle_on;

    complex_fir_real_taps_core #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    complex_fir_real_taps_checker #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_TDATA_W  (IN_TDATA_W)
    ) fir_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side backpressure: random stall bursts while idling is enabled
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 11) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Half uniform words, half the two's complement corners
    function automatic logic [COEF_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '1;
            3: return '0;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // One input transfer, optionally preceded by an idle burst
    task automatic send_item(input logic cmd, input logic first,
                             input logic [SAMPLE_BITS-1:0] si,
                             input logic [SAMPLE_BITS-1:0] sq,
                             input logic [IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] val);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_BITS-1:0] = {val, idx, sq, si};
        if (idle_on && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= {first, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Mostly samples with rare block starts; some loads, a few carrying a block mark
    task automatic send_random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            send_item(cfrt_pkg::CMD_FILTER, $urandom_range(0, 39) == 0,
                      pick_word(), pick_word(), IDX_W'($urandom), COEF_W'($urandom));
        end else begin
            send_item(cfrt_pkg::CMD_LOAD, roll >= 95, SAMPLE_BITS'($urandom),
                      SAMPLE_BITS'($urandom), IDX_W'($urandom_range(0, MAX_TAPS - 1)),
                      pick_word());
        end
    endtask

    // Drain the filter, let any trailing load settle, then write the tap count
    task automatic write_taps(input logic [cfrt_pkg::TAPS_W-1:0] value);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (MAX_TAPS + 4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [cfrt_pkg::TAPS_W-1:0] phase_taps [8];
        phase_taps = '{7'd0, 7'd127, 7'd1, 7'd65, 7'd64, 7'd0, 7'd0, 7'd33};
        phase_taps[5] = cfrt_pkg::TAPS_W'($urandom_range(0, 127));
        phase_taps[6] = cfrt_pkg::TAPS_W'($urandom_range(2, 63));

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        idle_on       = 1'b1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty bank gives zero, then corner coefficients at reset tap count
        send_item(cfrt_pkg::CMD_FILTER, 1'b1, WORD_MAX, WORD_MIN, '0, '0);
        // block mark on a load must leave the delay line alone
        send_item(cfrt_pkg::CMD_LOAD, 1'b1, '0, '0, 6'd0, WORD_MIN);
        send_item(cfrt_pkg::CMD_LOAD, 1'b0, '0, '0, 6'd1, WORD_MAX);
        // last tap in use at the reset count, and the one just past it
        send_item(cfrt_pkg::CMD_LOAD, 1'b0, '0, '0, 6'd32, WORD_MAX);
        send_item(cfrt_pkg::CMD_LOAD, 1'b0, '0, '0, 6'd33, WORD_MIN);
        send_item(cfrt_pkg::CMD_LOAD, 1'b0, '1, '1, 6'd63, 16'h0001);
        // samples continue the block across the loads
        send_item(cfrt_pkg::CMD_FILTER, 1'b0, WORD_MIN, WORD_MIN, '1, '1);
        send_item(cfrt_pkg::CMD_FILTER, 1'b0, WORD_MAX, WORD_MAX, '0, '0);
        send_item(cfrt_pkg::CMD_FILTER, 1'b0, '1, '0, '1, '0);
        send_item(cfrt_pkg::CMD_FILTER, 1'b1, 16'h0001, '1, '0, '1);
        send_item(cfrt_pkg::CMD_FILTER, 1'b0, WORD_MIN, WORD_MAX, '0, '0);

        // Fill the whole bank with random taps
        for (int k = 0; k < MAX_TAPS; k++) begin
            send_item(cfrt_pkg::CMD_LOAD, 1'b0, SAMPLE_BITS'($urandom),
                      SAMPLE_BITS'($urandom), IDX_W'(k), pick_word());
        end

        // Largest sums: every tap at the negative corner over a full block
        idle_on = 1'b0;
        write_taps(7'd64);
        for (int k = 0; k < MAX_TAPS; k++) begin
            send_item(cfrt_pkg::CMD_LOAD, 1'b0, '0, '0, IDX_W'(k), WORD_MIN);
        end
        for (int k = 0; k < MAX_TAPS + 6; k++) begin
            send_item(cfrt_pkg::CMD_FILTER, k == 0, WORD_MIN, WORD_MAX,
                      IDX_W'($urandom), COEF_W'($urandom));
        end

        // Random phases across tap counts; the last one runs without idling
        foreach (phase_taps[p]) begin
            idle_on = (p != 7);
            write_taps(phase_taps[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_random_item();
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (MAX_TAPS + 4) @(negedge i_clk);
        if (pending != 0) begin
            $error("%0d results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
